### rtl/core/complex_arithmetic_unit_defines.svh
// ----------------------------------------------------------------------------
// complex arithmetic unit assertion macros
// shared concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTH
`define CAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("complex arithmetic unit assertion failed");
`define CAU_ASSERT_NEVER(lbl, prop) \
  `CAU_ASSERT(lbl, !(prop))
`else
`define CAU_ASSERT(lbl, prop)
`define CAU_ASSERT_NEVER(lbl, prop)
`endif
`endif

### rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// complex arithmetic unit package
// shared constants, codes and item types
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int CAU_FRAC_BITS   = 16;
  localparam int DATA_W          = 32;
  localparam int DIV_STEPS       = 32;
  localparam int CAU_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_DIV_ZERO,
    ST_OVERFLOW
  } status_e;

  typedef struct packed {
    op_e                      op;
    logic                     div_zero;
    logic signed [DATA_W-1:0] ar;
    logic signed [DATA_W-1:0] ai;
    logic signed [DATA_W-1:0] br;
    logic signed [DATA_W-1:0] bi;
  } item_t;

endpackage

### rtl/core/cau_front.sv
// ----------------------------------------------------------------------------
// complex arithmetic unit front end
// accepts items, flags zero divisors and queues them for the back end
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_defines.svh"

module cau_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        opcode_i,
  input  logic signed [cau_pkg::DATA_W-1:0] a_real_i,
  input  logic signed [cau_pkg::DATA_W-1:0] a_imag_i,
  input  logic signed [cau_pkg::DATA_W-1:0] b_real_i,
  input  logic signed [cau_pkg::DATA_W-1:0] b_imag_i,
  output cau_pkg::item_t                    item_o,
  output logic                              item_valid_o,
  input  logic                              pop_i
);
  import cau_pkg::*;

  localparam int PtrW = $clog2(CAU_QUEUE_DEPTH);
  localparam int CntW = $clog2(CAU_QUEUE_DEPTH + 1);

  item_t           mem_q [CAU_QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  item_t           item_new;

  assign in_stall_o   = (count_q == CntW'(CAU_QUEUE_DEPTH));
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    item_new.op       = op_e'(opcode_i);
    item_new.div_zero = (op_e'(opcode_i) == OP_DIV) && (b_real_i == '0) && (b_imag_i == '0);
    item_new.ar       = a_real_i;
    item_new.ai       = a_imag_i;
    item_new.br       = b_real_i;
    item_new.bi       = b_imag_i;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + CntW'(push) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

### rtl/core/cau_divider.sv
// ----------------------------------------------------------------------------
// complex arithmetic unit divider
// pipelined restoring divider, two lanes sharing one divisor
// ----------------------------------------------------------------------------
module cau_divider #(
  parameter int FracBits = cau_pkg::CAU_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [63:0]                       mag_re_i,
  input  logic                              neg_re_i,
  input  logic [63:0]                       mag_im_i,
  input  logic                              neg_im_i,
  input  logic [63:0]                       den_i,
  output logic signed [cau_pkg::DATA_W-1:0] re_o,
  output logic signed [cau_pkg::DATA_W-1:0] im_o,
  output logic                              sat_o
);
  import cau_pkg::*;

  localparam int RemW = 64 + DIV_STEPS + FracBits;

  logic [RemW-1:0]   rem_re_q [DIV_STEPS];
  logic [RemW-1:0]   rem_im_q [DIV_STEPS];
  logic [63:0]       den_q    [DIV_STEPS];
  logic [DATA_W-1:0] quo_re_q [DIV_STEPS+1];
  logic [DATA_W-1:0] quo_im_q [DIV_STEPS+1];
  logic              neg_re_q [DIV_STEPS+1];
  logic              neg_im_q [DIV_STEPS+1];
  logic              sat_re_q [DIV_STEPS+1];
  logic              sat_im_q [DIV_STEPS+1];

  logic [RemW-1:0] n_re, n_im, d_top;

  // saturation check against the largest representable quotient
  always_comb begin
    n_re  = RemW'(mag_re_i) << FracBits;
    n_im  = RemW'(mag_im_i) << FracBits;
    d_top = RemW'(den_i) << (DIV_STEPS - 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_re_q[0] <= n_re;
      rem_im_q[0] <= n_im;
      den_q[0]    <= den_i;
      quo_re_q[0] <= '0;
      quo_im_q[0] <= '0;
      neg_re_q[0] <= neg_re_i;
      neg_im_q[0] <= neg_im_i;
      sat_re_q[0] <= neg_re_i ? (n_re >= d_top + RemW'(den_i)) : (n_re >= d_top);
      sat_im_q[0] <= neg_im_i ? (n_im >= d_top + RemW'(den_i)) : (n_im >= d_top);
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    localparam int Bit = DIV_STEPS - k;
    logic [RemW-1:0] dsh;
    logic            ge_re, ge_im;

    always_comb begin
      dsh   = RemW'(den_q[k-1]) << Bit;
      ge_re = (rem_re_q[k-1] >= dsh);
      ge_im = (rem_im_q[k-1] >= dsh);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_re_q[k] <= quo_re_q[k-1] | (DATA_W'(ge_re) << Bit);
        quo_im_q[k] <= quo_im_q[k-1] | (DATA_W'(ge_im) << Bit);
        neg_re_q[k] <= neg_re_q[k-1];
        neg_im_q[k] <= neg_im_q[k-1];
        sat_re_q[k] <= sat_re_q[k-1];
        sat_im_q[k] <= sat_im_q[k-1];
      end
    end

    if (k < DIV_STEPS) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_re_q[k] <= ge_re ? rem_re_q[k-1] - dsh : rem_re_q[k-1];
          rem_im_q[k] <= ge_im ? rem_im_q[k-1] - dsh : rem_im_q[k-1];
          den_q[k]    <= den_q[k-1];
        end
      end
    end
  end

  always_comb begin
    if (neg_re_q[DIV_STEPS]) begin
      re_o = sat_re_q[DIV_STEPS] ? {1'b1, {(DATA_W-1){1'b0}}} : $signed(~quo_re_q[DIV_STEPS] + 1'b1);
    end else begin
      re_o = sat_re_q[DIV_STEPS] ? {1'b0, {(DATA_W-1){1'b1}}} : $signed(quo_re_q[DIV_STEPS]);
    end
    if (neg_im_q[DIV_STEPS]) begin
      im_o = sat_im_q[DIV_STEPS] ? {1'b1, {(DATA_W-1){1'b0}}} : $signed(~quo_im_q[DIV_STEPS] + 1'b1);
    end else begin
      im_o = sat_im_q[DIV_STEPS] ? {1'b0, {(DATA_W-1){1'b1}}} : $signed(quo_im_q[DIV_STEPS]);
    end
    sat_o = sat_re_q[DIV_STEPS] || sat_im_q[DIV_STEPS];
  end

endmodule

### rtl/core/cau_back.sv
// ----------------------------------------------------------------------------
// complex arithmetic unit back end
// multiply, combine, divide and saturate, one item per cycle while the output is not stalled
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_defines.svh"

module cau_back #(
  parameter int FracBits = cau_pkg::CAU_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cau_pkg::item_t                    item_i,
  input  logic                              item_valid_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cau_pkg::DATA_W-1:0] result_real_o,
  output logic signed [cau_pkg::DATA_W-1:0] result_imag_o,
  output logic [1:0]                        status_o
);
  import cau_pkg::*;

  typedef struct packed {
    logic                     is_div;
    logic                     div_zero;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     sat;
  } side_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     sat;
  } clamp_t;

  function automatic clamp_t clamp32(input logic signed [64:0] v);
    clamp_t c;
    if (v > 65'sd2147483647) begin
      c.val = {1'b0, {(DATA_W-1){1'b1}}};
      c.sat = 1'b1;
    end else if (v < -65'sd2147483648) begin
      c.val = {1'b1, {(DATA_W-1){1'b0}}};
      c.sat = 1'b1;
    end else begin
      c.val = v[DATA_W-1:0];
      c.sat = 1'b0;
    end
    return c;
  endfunction

  logic en;

  // stage 1
  logic               s1_valid_q;
  op_e                s1_op_q;
  logic               s1_dz_q;
  logic signed [63:0] pp_rr_q, pp_ii_q, pp_ri_q, pp_ir_q, sq_r_q, sq_i_q;
  logic signed [32:0] sum_re_q, sum_im_q;

  // stage 2
  logic               s2_valid_q;
  side_t              s2_sb_q, s2_sb_d;
  logic [63:0]        s2_mag_re_q, s2_mag_im_q, s2_den_q;
  logic               s2_neg_re_q, s2_neg_im_q;
  logic signed [64:0] mul_re, mul_im, nre, nim;
  clamp_t             c_re, c_im;

  // divider side line
  logic  vld_q [DIV_STEPS+1];
  side_t sb_q  [DIV_STEPS+1];

  logic signed [DATA_W-1:0] div_re, div_im;
  logic                     div_sat;

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] res_re_q, res_im_q;
  status_e                  status_q;

  assign en            = !out_valid_q || !out_stall_i;
  assign pop_o         = en && item_valid_i;
  assign out_valid_o   = out_valid_q;
  assign result_real_o = res_re_q;
  assign result_imag_o = res_im_q;
  assign status_o      = status_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q  <= item_i.op;
      s1_dz_q  <= item_i.div_zero;
      pp_rr_q  <= $signed(item_i.ar) * $signed(item_i.br);
      pp_ii_q  <= $signed(item_i.ai) * $signed(item_i.bi);
      pp_ri_q  <= $signed(item_i.ar) * $signed(item_i.bi);
      pp_ir_q  <= $signed(item_i.ai) * $signed(item_i.br);
      sq_r_q   <= $signed(item_i.br) * $signed(item_i.br);
      sq_i_q   <= $signed(item_i.bi) * $signed(item_i.bi);
      if (item_i.op == OP_SUB) begin
        sum_re_q <= $signed({item_i.ar[DATA_W-1], item_i.ar}) -
                    $signed({item_i.br[DATA_W-1], item_i.br});
        sum_im_q <= $signed({item_i.ai[DATA_W-1], item_i.ai}) -
                    $signed({item_i.bi[DATA_W-1], item_i.bi});
      end else begin
        sum_re_q <= $signed({item_i.ar[DATA_W-1], item_i.ar}) +
                    $signed({item_i.br[DATA_W-1], item_i.br});
        sum_im_q <= $signed({item_i.ai[DATA_W-1], item_i.ai}) +
                    $signed({item_i.bi[DATA_W-1], item_i.bi});
      end
    end
  end

  always_comb begin
    mul_re = ($signed({pp_rr_q[63], pp_rr_q}) - $signed({pp_ii_q[63], pp_ii_q})) >>> FracBits;
    mul_im = ($signed({pp_ri_q[63], pp_ri_q}) + $signed({pp_ir_q[63], pp_ir_q})) >>> FracBits;
    nre    = $signed({pp_rr_q[63], pp_rr_q}) + $signed({pp_ii_q[63], pp_ii_q});
    nim    = $signed({pp_ir_q[63], pp_ir_q}) - $signed({pp_ri_q[63], pp_ri_q});
    case (s1_op_q)
      OP_MUL: begin
        c_re = clamp32(mul_re);
        c_im = clamp32(mul_im);
      end
      default: begin
        c_re = clamp32(65'(sum_re_q));
        c_im = clamp32(65'(sum_im_q));
      end
    endcase
    s2_sb_d.is_div   = (s1_op_q == OP_DIV);
    s2_sb_d.div_zero = s1_dz_q;
    s2_sb_d.re       = c_re.val;
    s2_sb_d.im       = c_im.val;
    s2_sb_d.sat      = c_re.sat || c_im.sat;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sb_q     <= s2_sb_d;
      s2_neg_re_q <= nre[64];
      s2_neg_im_q <= nim[64];
      s2_mag_re_q <= nre[64] ? 64'(-nre) : 64'(nre);
      s2_mag_im_q <= nim[64] ? 64'(-nim) : 64'(nim);
      s2_den_q    <= $unsigned(sq_r_q + sq_i_q);
    end
  end

  cau_divider #(
    .FracBits(FracBits)
  ) u_divider (
    .clk_i   (clk_i),
    .en_i    (en),
    .mag_re_i(s2_mag_re_q),
    .neg_re_i(s2_neg_re_q),
    .mag_im_i(s2_mag_im_q),
    .neg_im_i(s2_neg_im_q),
    .den_i   (s2_den_q),
    .re_o    (div_re),
    .im_o    (div_im),
    .sat_o   (div_sat)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= s2_sb_q;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      s1_valid_q  <= item_valid_i;
      s2_valid_q  <= s1_valid_q;
      vld_q[0]    <= s2_valid_q;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_valid_q <= vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!sb_q[DIV_STEPS].is_div) begin
        res_re_q <= sb_q[DIV_STEPS].re;
        res_im_q <= sb_q[DIV_STEPS].im;
        status_q <= sb_q[DIV_STEPS].sat ? ST_OVERFLOW : ST_OK;
      end else if (sb_q[DIV_STEPS].div_zero) begin
        res_re_q <= '0;
        res_im_q <= '0;
        status_q <= ST_DIV_ZERO;
      end else begin
        res_re_q <= div_re;
        res_im_q <= div_im;
        status_q <= div_sat ? ST_OVERFLOW : ST_OK;
      end
    end
  end

  `CAU_ASSERT(a_status_code, out_valid_q |-> status_q != status_e'(2'd3))
  `CAU_ASSERT(a_div_zero_result, out_valid_q && status_q == ST_DIV_ZERO |-> res_re_q == '0 && res_im_q == '0)
  `CAU_ASSERT(a_den_nonzero, s2_valid_q && s2_sb_q.is_div && !s2_sb_q.div_zero |-> s2_den_q != '0)

endmodule

### rtl/core/complex_arithmetic_unit.sv
// pipeline: input queue, stage 1, stage 2, divider input and steps, then the result register
// throughput: one item per cycle when not stalled, set by the fully pipelined 32-step divider and multipliers
// a 4-entry input queue decouples the input side from output stalls
// reset: asynchronous active low, clears the queue and all pipeline valid bits
// ----------------------------------------------------------------------------
// complex arithmetic unit
// add, subtract, multiply and divide of signed fixed point complex operands
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int FracBits = cau_pkg::CAU_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        opcode_i,
  input  logic signed [cau_pkg::DATA_W-1:0] a_real_i,
  input  logic signed [cau_pkg::DATA_W-1:0] a_imag_i,
  input  logic signed [cau_pkg::DATA_W-1:0] b_real_i,
  input  logic signed [cau_pkg::DATA_W-1:0] b_imag_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cau_pkg::DATA_W-1:0] result_real_o,
  output logic signed [cau_pkg::DATA_W-1:0] result_imag_o,
  output logic [1:0]                        status_o
);
  import cau_pkg::*;

  item_t item;
  logic  item_valid;
  logic  pop;

  cau_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .a_real_i    (a_real_i),
    .a_imag_i    (a_imag_i),
    .b_real_i    (b_real_i),
    .b_imag_i    (b_imag_i),
    .item_o      (item),
    .item_valid_o(item_valid),
    .pop_i       (pop)
  );

  cau_back #(
    .FracBits(FracBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_real_o(result_real_o),
    .result_imag_o(result_imag_o),
    .status_o     (status_o)
  );

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// complex arithmetic unit testbench
// drives random and corner-case operand pairs through all four operations,
// predicts each result in Q16.16 with saturation and compares every field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import cau_pkg::*;

  localparam int NUM_RANDOM = 1030;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    op_e op;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
  } operands_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    status_e st;
  } cplx_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] opcode_i = '0;
  logic signed [31:0] a_real_i = '0, a_imag_i = '0, b_real_i = '0, b_imag_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] result_real_o, result_imag_o;
  logic [1:0] status_o;

  operands_t pending_q[$];
  cplx_result_t awaited_q[$];
  int mismatches = 0;
  int cycles = 0;
  bit feeding_done = 1'b0;
  bit hold_for_drain = 1'b0;
  int in_gap = 0, out_gap = 0;

  complex_arithmetic_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [31:0] clamp_part(logic signed [127:0] v, ref bit sat);
    if (v > 128'sd2147483647) begin sat = 1'b1; return 32'h7fffffff; end
    if (v < -128'sd2147483648) begin sat = 1'b1; return 32'h80000000; end
    return v[31:0];
  endfunction

  // numerator * 2^16 / den, truncated toward zero
  function automatic logic signed [127:0] div_trunc(logic signed [127:0] num,
                                                     logic signed [127:0] den);
    logic [127:0] mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag << CAU_FRAC_BITS) / den;
    return (num < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic cplx_result_t complex_op(operands_t x);
    cplx_result_t res;
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    bit sat;
    sat = 1'b0;
    ar = x.ar; ai = x.ai; br = x.br; bi = x.bi;
    res.st = ST_OK;
    re = 0; im = 0;
    case (x.op)
      OP_ADD: begin re = ar + br; im = ai + bi; end
      OP_SUB: begin re = ar - br; im = ai - bi; end
      OP_MUL: begin
        re = (ar * br - ai * bi) >>> CAU_FRAC_BITS;
        im = (ar * bi + ai * br) >>> CAU_FRAC_BITS;
      end
      default: begin
        den = br * br + bi * bi;
        if (den != 0) begin
          re = div_trunc(ar * br + ai * bi, den);
          im = div_trunc(ai * br - ar * bi, den);
        end
      end
    endcase
    res.re = clamp_part(re, sat);
    res.im = clamp_part(im, sat);
    if (x.op == OP_DIV && den == 0) res.st = ST_DIV_ZERO;
    if (sat) res.st = ST_OVERFLOW;
    return res;
  endfunction

  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3) == 0 ? 32'h80000000 : 32'h7fffffff;
      1: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      2: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      3: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  function automatic operands_t make_item(op_e op, logic [31:0] ar, logic [31:0] ai,
                                          logic [31:0] br, logic [31:0] bi);
    operands_t x;
    x.op = op; x.ar = ar; x.ai = ai; x.br = br; x.bi = bi;
    return x;
  endfunction

  initial begin
    logic [31:0] mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    pending_q.push_back(make_item(OP_ADD, mx, mn, mx, mn));
    pending_q.push_back(make_item(OP_ADD, 32'h10000, 32'hffff0000, 32'h8000, 32'h1));
    pending_q.push_back(make_item(OP_SUB, mn, mx, mx, mn));
    pending_q.push_back(make_item(OP_SUB, 32'h30000, 32'h0, 32'h10000, 32'hffffffff));
    pending_q.push_back(make_item(OP_MUL, 32'h20000, 32'h10000, 32'h30000, 32'hffff0000));
    pending_q.push_back(make_item(OP_MUL, mn, mn, mn, mn));
    pending_q.push_back(make_item(OP_MUL, mx, mx, mx, mn));
    pending_q.push_back(make_item(OP_MUL, 32'hffffffff, 32'h0, 32'h1, 32'h0));
    pending_q.push_back(make_item(OP_MUL, 32'hffffffff, 32'hffffffff, 32'h1, 32'h1));
    pending_q.push_back(make_item(OP_DIV, 32'h10000, 32'h10000, 32'h0, 32'h0));
    pending_q.push_back(make_item(OP_DIV, mx, mn, 32'h0, 32'h0));
    pending_q.push_back(make_item(OP_DIV, 32'h60000, 32'h20000, 32'h20000, 32'h0));
    pending_q.push_back(make_item(OP_DIV, 32'hfffb0000, 32'h10000, 32'h0, 32'h30000));
    pending_q.push_back(make_item(OP_DIV, mx, mx, 32'h1, 32'h0));
    pending_q.push_back(make_item(OP_DIV, mn, 32'h0, 32'h10000, 32'h0));
    pending_q.push_back(make_item(OP_DIV, mn, mn, mn, mn));
    pending_q.push_back(make_item(OP_DIV, 32'h1, 32'hffffffff, mx, mx));
    pending_q.push_back(make_item(OP_DIV, 32'hffffffff, 32'h0, 32'h3, 32'h0));
    pending_q.push_back(make_item(OP_DIV, mn, 32'h0, 32'hffff0000, 32'h0));
    for (int i = 0; i < NUM_RANDOM; i++)
      pending_q.push_back(make_item(op_e'($urandom_range(0, 3)), rand_part(), rand_part(),
                                    rand_part(), rand_part()));
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  always @(posedge clk_i) begin
    operands_t x;
    bit idle;
    bit hold;
    int gap;
    if (rst_ni) begin
      idle = !in_valid_i;
      hold = hold_for_drain;
      gap = in_gap;
      if (in_valid_i && !in_stall_o) begin
        awaited_q.push_back(complex_op(pending_q.pop_front()));
        idle = 1'b1;
        gap = pick_gap();
        if (pending_q.size() == 400) hold = 1'b1;
      end
      if (idle) begin
        if (hold) begin
          if (awaited_q.size() == 0) hold = 1'b0;
          in_valid_i <= 1'b0;
        end else if (gap > 0) begin
          gap = gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          x = pending_q[0];
          in_valid_i <= 1'b1;
          opcode_i <= x.op;
          a_real_i <= x.ar; a_imag_i <= x.ai;
          b_real_i <= x.br; b_imag_i <= x.bi;
        end else begin
          in_valid_i <= 1'b0;
          feeding_done <= 1'b1;
        end
      end
      in_gap <= gap;
      hold_for_drain <= hold;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cplx_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h %h %0d",
                                         result_real_o, result_imag_o, status_o);
        end else begin
          want = awaited_q.pop_front();
          if (want.re !== result_real_o || want.im !== result_imag_o
              || want.st !== status_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %h %h %0d got %h %h %0d", want.re, want.im, want.st,
                       result_real_o, result_imag_o, status_o);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_gap <= pick_gap();
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    while (!(feeding_done && awaited_q.size() == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      if (mismatches == 0 && awaited_q.size() == 0) begin
        $display("TB_OK");
      end else begin
        $display("TB_ERROR");
      end
      $finish;
    end
  end

endmodule

### complex_arithmetic_unit.f
+incdir+rtl/core
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_divider.sv
rtl/core/cau_back.sv
rtl/core/complex_arithmetic_unit.sv
bench/testbench.sv
